[rtl/salc_pkg.sv]
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup package
// Geometry constants, row types, register map and the status struct that is
// shared between the top level and the way update logic.
// ----------------------------------------------------------------------------
package salc_pkg;

  // Cache geometry. SET_COUNT and WAY_COUNT are powers of two.
  localparam int SET_COUNT = 64;
  localparam int WAY_COUNT = 4;
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = ADDR_W;
  localparam int SET_W     = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int RANK_W    = WAY_W;
  localparam int CNT_W     = $clog2(WAY_COUNT + 1);
  localparam int SPLIT_W   = 6;
  localparam int COUNT_W   = 32;

  // Configuration register widths and reset values.
  localparam int OFFSET_BITS_W = 5;
  localparam int INDEX_BITS_W  = 3;
  localparam int WAYS_W        = 3;
  localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RST = 5'd2;
  localparam logic [INDEX_BITS_W-1:0]  INDEX_BITS_RST  = 3'd6;
  localparam logic [WAYS_W-1:0]        WAYS_RST        = 3'd4;

  // APB register map: register i sits at byte address 4*i.
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One set row as it is kept in the tag and rank memories.
  typedef logic [WAY_COUNT-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [WAY_COUNT-1:0][RANK_W-1:0] rank_row_t;
  typedef logic [WAY_COUNT-1:0]             valid_row_t;

  // Outcome of one lookup, from the way update logic.
  typedef struct packed {
    logic       hit;
    logic       evicted;
    valid_row_t valid;
  } upd_status_t;

endpackage

[rtl/salc_if.sv]
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup channels
// Request channel carries one address word; response channel carries the
// lookup outcome and the running hit and miss counts.
// ----------------------------------------------------------------------------
interface salc_req_if;
  logic                      valid;
  logic                      ready;
  logic [salc_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface salc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        evicted;
  logic [salc_pkg::COUNT_W-1:0] hit_count;
  logic [salc_pkg::COUNT_W-1:0] miss_count;

  modport source (output valid, output hit, output evicted, output hit_count,
                  output miss_count, input ready);
  modport sink   (input valid, input hit, input evicted, input hit_count,
                  input miss_count, output ready);
endinterface

[rtl/salc_way_update.sv]
// ----------------------------------------------------------------------------
// Way update logic
// Compares a tag with the ways of one set row and produces the row to write
// back: recency ranks, tags and valid marks, plus hit and eviction status.
// ----------------------------------------------------------------------------
module salc_way_update (
  input  salc_pkg::tag_row_t          tags,
  input  salc_pkg::rank_row_t         ranks,
  input  salc_pkg::valid_row_t        vrow,
  input  logic [salc_pkg::TAG_W-1:0]  tag,
  input  logic [salc_pkg::CNT_W-1:0]  ways,
  output salc_pkg::upd_status_t       upd,
  output salc_pkg::tag_row_t          new_tags,
  output salc_pkg::rank_row_t         new_ranks
);

  salc_pkg::rank_row_t               rk;
  logic                              found_any;
  logic [salc_pkg::WAY_W-1:0]        found_way;
  logic                              free_any;
  logic [salc_pkg::WAY_W-1:0]        free_way;
  logic                              vic_any;
  logic [salc_pkg::WAY_W-1:0]        vic_way;
  logic [salc_pkg::RANK_W-1:0]       best;
  logic [salc_pkg::CNT_W-1:0]        count;
  logic                              is_fill;
  logic                              age_all;
  logic [salc_pkg::WAY_W-1:0]        sel_way;
  logic [salc_pkg::RANK_W-1:0]       limit;

  // Scan the ways: first match, first free way, fill count and the oldest
  // valid way (lowest number wins a tie). Ranks of invalid ways read as zero.
  always_comb begin
    found_any = 1'b0;
    found_way = '0;
    free_any  = 1'b0;
    free_way  = '0;
    vic_any   = 1'b0;
    vic_way   = '0;
    best      = '0;
    count     = '0;
    for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
      rk[w] = vrow[w] ? ranks[w] : '0;
      count = count + salc_pkg::CNT_W'(vrow[w]);
      if (!found_any && vrow[w] && (tags[w] == tag)) begin
        found_any = 1'b1;
        found_way = salc_pkg::WAY_W'(w);
      end
      if (!free_any && !vrow[w]) begin
        free_any = 1'b1;
        free_way = salc_pkg::WAY_W'(w);
      end
      if (vrow[w] && (!vic_any || (rk[w] > best))) begin
        vic_any = 1'b1;
        vic_way = salc_pkg::WAY_W'(w);
        best    = rk[w];
      end
    end
  end

  // Choose the way that becomes most recently used and how the others age.
  // A miss fills a free way while the set holds fewer than the ways in use.
  always_comb begin
    is_fill = !found_any && (count < ways);
    age_all = is_fill;
    if (found_any) begin
      sel_way = found_way;
      limit   = rk[found_way];
    end else if (is_fill) begin
      sel_way = free_way;
      limit   = '0;
    end else begin
      sel_way = vic_way;
      limit   = best;
    end
  end

  // Build the row to write back.
  always_comb begin
    for (int w = 0; w < salc_pkg::WAY_COUNT; w++) begin
      new_tags[w]  = tags[w];
      new_ranks[w] = ranks[w];
      if (vrow[w] && (age_all || (rk[w] < limit))) begin
        new_ranks[w] = salc_pkg::RANK_W'(rk[w] + 1'b1);
      end
    end
    new_ranks[sel_way] = '0;
    if (!found_any) begin
      new_tags[sel_way] = tag;
    end
    upd.valid          = vrow;
    upd.valid[sel_way] = 1'b1;
    upd.hit            = found_any;
    upd.evicted        = !found_any && !is_fill;
  end

endmodule

[rtl/set_assoc_lru_cache_lookup.sv]
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup
// Splits each address into offset, set and tag, looks the tag up in its set,
// updates LRU order and fills or replaces a way on a miss; counts hits/misses.
// ----------------------------------------------------------------------------
// The block takes one address word per clock while the response side is not
// stalled and returns one response word per address, in order. The rate of
// one word per cycle is set by the single read-modify-write of one set row
// per cycle: the row is read from the tag and rank memories into the compare
// stage, updated there and written back as the word leaves that stage, and a
// following address to the same set picks the updated row from a bypass.
// Valid marks sit in flip-flops cleared by reset, so no clearing pass is
// needed and the block is ready right out of reset. Configuration writes
// are meant for idle periods; the hit and miss counts saturate at all ones.
module set_assoc_lru_cache_lookup (
  input  logic                           clk,
  input  logic                           rst,
  salc_req_if.sink                       req,
  salc_rsp_if.source                     rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [salc_pkg::PADDR_W-1:0]   paddr,
  input  logic [salc_pkg::PDATA_W-1:0]   pwdata,
  output logic [salc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  // Configuration registers.
  logic [salc_pkg::OFFSET_BITS_W-1:0] offset_bits;
  logic [salc_pkg::INDEX_BITS_W-1:0]  index_bits;
  logic [salc_pkg::WAYS_W-1:0]        ways_in_use;
  logic [salc_pkg::CNT_W-1:0]         ways_eff;
  logic [salc_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                               cfg_write;

  // Pipeline control.
  logic a_valid;
  logic b_valid;
  logic res_valid;
  logic out_en;
  logic b_load;
  logic a_load;
  logic b_leave;
  logic fwd;

  // Stage A: address split.
  logic [salc_pkg::ADDR_W-1:0]  a_addr;
  logic [salc_pkg::ADDR_W-1:0]  a_shifted;
  logic [salc_pkg::SPLIT_W-1:0] a_split;
  logic [salc_pkg::SET_W-1:0]   set_mask;
  logic [salc_pkg::SET_W-1:0]   a_set;
  logic [salc_pkg::TAG_W-1:0]   a_tag;

  // Stage B: row compare and update.
  logic [salc_pkg::SET_W-1:0]   b_set;
  logic [salc_pkg::TAG_W-1:0]   b_tag;
  salc_pkg::tag_row_t           rd_tags;
  salc_pkg::rank_row_t          rd_ranks;
  salc_pkg::valid_row_t         b_vrow;
  salc_pkg::upd_status_t        upd;
  salc_pkg::tag_row_t           new_tags;
  salc_pkg::rank_row_t          new_ranks;

  // State.
  salc_pkg::tag_row_t           tag_mem   [salc_pkg::SET_COUNT];
  salc_pkg::rank_row_t          rank_mem  [salc_pkg::SET_COUNT];
  salc_pkg::valid_row_t         valid_bits[salc_pkg::SET_COUNT];
  logic [salc_pkg::COUNT_W-1:0] hit_total;
  logic [salc_pkg::COUNT_W-1:0] miss_total;
  logic [salc_pkg::COUNT_W-1:0] hit_total_next;
  logic [salc_pkg::COUNT_W-1:0] miss_total_next;
  logic                         res_hit;
  logic                         res_evicted;

  // APB register port.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[salc_pkg::PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= salc_pkg::OFFSET_BITS_RST;
      index_bits  <= salc_pkg::INDEX_BITS_RST;
      ways_in_use <= salc_pkg::WAYS_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        salc_pkg::REG_OFFSET_BITS: offset_bits <= pwdata[salc_pkg::OFFSET_BITS_W-1:0];
        salc_pkg::REG_INDEX_BITS:  index_bits  <= pwdata[salc_pkg::INDEX_BITS_W-1:0];
        salc_pkg::REG_WAYS_IN_USE: ways_in_use <= pwdata[salc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      salc_pkg::REG_OFFSET_BITS: prdata = salc_pkg::PDATA_W'(offset_bits);
      salc_pkg::REG_INDEX_BITS:  prdata = salc_pkg::PDATA_W'(index_bits);
      salc_pkg::REG_WAYS_IN_USE: prdata = salc_pkg::PDATA_W'(ways_in_use);
      default:                   prdata = '0;
    endcase
  end

  // Ways in use, clamped to the range 1 to WAY_COUNT.
  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = salc_pkg::CNT_W'(1);
    end else if (int'(ways_in_use) > salc_pkg::WAY_COUNT) begin
      ways_eff = salc_pkg::CNT_W'(salc_pkg::WAY_COUNT);
    end else begin
      ways_eff = salc_pkg::CNT_W'(ways_in_use);
    end
  end

  // Handshake: each stage loads when it is empty or its word moves on.
  assign out_en    = !res_valid || rsp.ready;
  assign b_load    = !b_valid || out_en;
  assign a_load    = !a_valid || b_load;
  assign b_leave   = b_valid && out_en;
  assign req.ready = a_load;

  // Address split. The set number keeps the low set bits of the index field,
  // and the tag is zero when offset and index cover the whole address.
  assign a_shifted = a_addr >> offset_bits;
  assign a_split   = salc_pkg::SPLIT_W'(offset_bits) + salc_pkg::SPLIT_W'(index_bits);

  always_comb begin
    for (int i = 0; i < salc_pkg::SET_W; i++) begin
      set_mask[i] = (i < int'(index_bits));
    end
  end

  assign a_set = a_shifted[salc_pkg::SET_W-1:0] & set_mask;
  assign a_tag = (a_split >= salc_pkg::SPLIT_W'(salc_pkg::ADDR_W)) ? '0 : (a_addr >> a_split);

  // Control registers of the pipeline, valid marks and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      res_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
      for (int s = 0; s < salc_pkg::SET_COUNT; s++) begin
        valid_bits[s] <= '0;
      end
    end else begin
      if (a_load) begin
        a_valid <= req.valid;
      end
      if (b_load) begin
        b_valid <= a_valid;
      end
      if (out_en) begin
        res_valid <= b_valid;
      end
      if (b_leave) begin
        valid_bits[b_set] <= upd.valid;
        hit_total         <= hit_total_next;
        miss_total        <= miss_total_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_addr <= req.address;
    end
    if (b_load) begin
      b_set <= a_set;
      b_tag <= a_tag;
    end
    if (out_en) begin
      res_hit     <= upd.hit;
      res_evicted <= upd.evicted;
    end
  end

  // Tag and rank memories: at most one row read and one row written per cycle. A read
  // of the set being written in the same cycle takes the new row instead.
  assign fwd = b_leave && (b_set == a_set);

  always_ff @(posedge clk) begin
    if (b_leave) begin
      tag_mem[b_set]  <= new_tags;
      rank_mem[b_set] <= new_ranks;
    end
    if (b_load) begin
      if (fwd) begin
        rd_tags  <= new_tags;
        rd_ranks <= new_ranks;
      end else begin
        rd_tags  <= tag_mem[a_set];
        rd_ranks <= rank_mem[a_set];
      end
    end
  end

  assign b_vrow = valid_bits[b_set];

  salc_way_update u_way_update (
    .tags      (rd_tags),
    .ranks     (rd_ranks),
    .vrow      (b_vrow),
    .tag       (b_tag),
    .ways      (ways_eff),
    .upd       (upd),
    .new_tags  (new_tags),
    .new_ranks (new_ranks)
  );

  // Saturating counters.
  always_comb begin
    hit_total_next  = hit_total;
    miss_total_next = miss_total;
    if (upd.hit) begin
      if (hit_total != salc_pkg::COUNT_MAX) begin
        hit_total_next = hit_total + 1'b1;
      end
    end else begin
      if (miss_total != salc_pkg::COUNT_MAX) begin
        miss_total_next = miss_total + 1'b1;
      end
    end
  end

  // Response word.
  assign rsp.valid      = res_valid;
  assign rsp.hit        = res_hit;
  assign rsp.evicted    = res_evicted;
  assign rsp.hit_count  = hit_total;
  assign rsp.miss_count = miss_total;

`ifndef ASSERT_OFF
  // A replacement only happens in a set that holds at least the ways in use.
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (b_leave && upd.evicted) |-> ($countones(b_vrow) >= int'(ways_eff)))
    else $error("eviction from a set that was not full");

  // A hit below saturation advances the hit count by exactly one.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (b_leave && upd.hit && (hit_total != salc_pkg::COUNT_MAX))
      |=> (hit_total == $past(hit_total) + 32'd1))
    else $error("hit count did not advance on a hit");

  // A word held in the split stage keeps its address while the pipeline stalls.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_load) |=> (a_valid && $stable(a_addr)))
    else $error("stalled address changed");
`endif

endmodule

[tb/tb_set_assoc_lru_cache_lookup.sv]
// ----------------------------------------------------------------------------
// Testbench for the set-associative LRU cache lookup
// Sends address words, predicts every response word with a behavioral copy of
// the cache (tags, valid marks, recency ranks, saturating counters) and checks
// them in order. A short directed table covers the corner cases. Random phases
// then sweep the register settings and the handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_lookup;
  import salc_pkg::*;

  localparam int ENTRIES    = SET_COUNT * WAY_COUNT;
  localparam int HOLD_LEN   = 64;
  localparam int QUIET_MAX  = 1000;
  localparam int PHASE_LEN  = 55;
  localparam int PHASES     = 9;
  localparam int DIR_ROWS   = 28;

  typedef enum bit [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum bit {ROW_ACCESS, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
  } lookup_res_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [REG_IDX_W-1:0]  sel;
    logic [31:0]           value;
    bit                    typed;
    lookup_res_t           want;
  } stim_row_t;

  typedef struct packed {
    logic [OFFSET_BITS_W-1:0] offset;
    logic [INDEX_BITS_W-1:0]  index;
    logic [WAYS_W-1:0]        ways;
    idle_mode_t               mode;
  } phase_cfg_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  salc_req_if req_ch ();
  salc_rsp_if rsp_ch ();

  set_assoc_lru_cache_lookup dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Behavioral copy of the cache contents and its registers.
  logic [TAG_W-1:0]         tag_mem   [ENTRIES];
  bit                       valid_mem [ENTRIES];
  int unsigned              rank_mem  [ENTRIES];
  logic [COUNT_W-1:0]       hit_total;
  logic [COUNT_W-1:0]       miss_total;
  logic [OFFSET_BITS_W-1:0] cur_offset;
  logic [INDEX_BITS_W-1:0]  cur_index;
  logic [WAYS_W-1:0]        cur_ways;

  lookup_res_t pending_lookups [$];
  int          mismatch_count;
  int          gap_pct;
  int          stall_pct;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  int          quiet_cycles;
  logic [31:0] tag_pool [6];
  logic [31:0] set_pool [3];

  // Directed table: corner cases first, typed where the result is obvious.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd1}},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0003, 1'b1, '{1'b1, 1'b0, 32'd1, 32'd1}},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'd1, 32'd2}},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'hFFFF_FFFC, 1'b1, '{1'b1, 1'b0, 32'd2, 32'd2}},
    // Fill set 0 and then force two evictions.
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0100, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0200, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0300, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0400, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0000, 1'b0, '0},
    // Associativity cut while the set is full: all valid ways still hit.
    '{ROW_CFG,    REG_WAYS_IN_USE, 32'd1,         1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0300, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0500, 1'b0, '0},
    '{ROW_CFG,    REG_WAYS_IN_USE, 32'd0,         1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0600, 1'b0, '0},
    '{ROW_CFG,    REG_WAYS_IN_USE, 32'd7,         1'b0, '0},
    // Offset and index together cover the whole address, so the tag is zero.
    '{ROW_CFG,    REG_OFFSET_BITS, 32'd31,        1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h8000_0000, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0001, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h8000_0000, 1'b0, '0},
    // Index wider than the set count: upper index bits fold onto one set.
    '{ROW_CFG,    REG_OFFSET_BITS, 32'd0,         1'b0, '0},
    '{ROW_CFG,    REG_INDEX_BITS,  32'd7,         1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0040, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_00C0, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h0000_0040, 1'b0, '0},
    // A single set in use.
    '{ROW_CFG,    REG_INDEX_BITS,  32'd0,         1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h1234_5678, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'hEDCB_A987, 1'b0, '0},
    '{ROW_ACCESS, REG_OFFSET_BITS, 32'h1234_5678, 1'b0, '0}
  };

  // Register settings and idling pattern of each random phase.
  phase_cfg_t phase_list [PHASES] = '{
    '{5'd2,  3'd6, 3'd4, IDLE_NONE},
    '{5'd4,  3'd3, 3'd2, IDLE_SEND},
    '{5'd0,  3'd0, 3'd4, IDLE_RECV},
    '{5'd31, 3'd6, 3'd4, IDLE_BOTH},
    '{5'd5,  3'd1, 3'd1, IDLE_NONE},
    '{5'd3,  3'd2, 3'd3, IDLE_SEND},
    '{5'd8,  3'd7, 3'd7, IDLE_RECV},
    '{5'd1,  3'd4, 3'd0, IDLE_BOTH},
    '{5'd12, 3'd5, 3'd4, IDLE_NONE}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Age every valid way of the set whose rank is below the limit.
  function automatic void age_ways(input int unsigned base, input int unsigned lim);
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (valid_mem[base + w] && rank_mem[base + w] < lim) begin
        rank_mem[base + w]++;
      end
    end
  endfunction

  // One lookup against the cache copy: hit, fill or LRU replacement.
  function automatic lookup_res_t predict_lookup(input logic [31:0] a);
    lookup_res_t r;
    int unsigned split, base, ways, found, free_w, cnt, victim, best;
    logic [63:0] idx_field;
    logic [TAG_W-1:0] tagv;
    r = '0;
    split = 32'(cur_offset) + 32'(cur_index);
    idx_field = (64'(a) >> cur_offset) & ((64'd1 << cur_index) - 64'd1);
    tagv = (split >= 32) ? '0 : TAG_W'(a >> split);
    base = 32'(idx_field % SET_COUNT) * WAY_COUNT;
    ways = (cur_ways == 0) ? 1 : (cur_ways > WAY_COUNT) ? WAY_COUNT : 32'(cur_ways);
    found = WAY_COUNT;
    free_w = WAY_COUNT;
    cnt = 0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (valid_mem[base + w]) begin
        cnt++;
        if (found == WAY_COUNT && tag_mem[base + w] == tagv) found = w;
      end else if (free_w == WAY_COUNT) begin
        free_w = w;
      end
    end
    if (found < WAY_COUNT) begin
      r.hit = 1'b1;
      hit_total = sat_inc(hit_total);
      age_ways(base, rank_mem[base + found]);
      rank_mem[base + found] = 0;
    end else begin
      miss_total = sat_inc(miss_total);
      if (cnt < ways && free_w < WAY_COUNT) begin
        age_ways(base, WAY_COUNT);
        valid_mem[base + free_w] = 1'b1;
        tag_mem[base + free_w] = tagv;
        rank_mem[base + free_w] = 0;
      end else begin
        // Replace the valid way with the largest rank, lowest way on a tie.
        victim = WAY_COUNT;
        best = 0;
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (valid_mem[base + w] && (victim == WAY_COUNT || rank_mem[base + w] > best)) begin
            victim = w;
            best = rank_mem[base + w];
          end
        end
        if (victim < WAY_COUNT) begin
          r.evicted = 1'b1;
          age_ways(base, best);
          tag_mem[base + victim] = tagv;
          rank_mem[base + victim] = 0;
        end
      end
    end
    r.hits = hit_total;
    r.misses = miss_total;
    return r;
  endfunction

  // Address from the phase's small tag and set pools with a random offset.
  function automatic logic [31:0] pool_addr();
    int unsigned split;
    logic [63:0] v;
    split = 32'(cur_offset) + 32'(cur_index);
    v = (64'(tag_pool[$urandom_range(5)]) << split)
      | ((64'(set_pool[$urandom_range(2)]) & ((64'd1 << cur_index) - 64'd1)) << cur_offset)
      | (64'($urandom) & ((64'd1 << cur_offset) - 64'd1));
    return v[31:0];
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] sel,
                                                   input logic [31:0] val);
    case (sel)
      REG_OFFSET_BITS: return PDATA_W'(val[OFFSET_BITS_W-1:0]);
      REG_INDEX_BITS:  return PDATA_W'(val[INDEX_BITS_W-1:0]);
      default:         return PDATA_W'(val[WAYS_W-1:0]);
    endcase
  endfunction

  // Offer one address word, with random gaps, and predict once it is taken.
  task automatic send_lookup(input logic [31:0] a, input bit typed, input lookup_res_t want);
    lookup_res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.address <= a;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_lookup(a);
    if (typed) predicted = want;
    pending_lookups = {pending_lookups, predicted};
  endtask

  // Stop offering and wait until every expected response word has come.
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  // Register write followed by a read-back of the same register.
  task automatic write_reg(input logic [REG_IDX_W-1:0] sel, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({sel, 2'b00});
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_OFFSET_BITS: cur_offset = val[OFFSET_BITS_W-1:0];
      REG_INDEX_BITS:  cur_index  = val[INDEX_BITS_W-1:0];
      default:         cur_ways   = val[WAYS_W-1:0];
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(sel, val)) begin
      report_mismatch($sformatf("register %0d read %0h, expected %0h",
                                sel, prdata, reg_value(sel, val)));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Response side: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_LEN - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each response word with the oldest prediction.
  always @(posedge clk) begin
    lookup_res_t exp_res;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("response word with no lookup pending");
      end else begin
        exp_res = pending_lookups.pop_front();
        if (rsp_ch.hit !== exp_res.hit)
          report_mismatch($sformatf("hit %0b, expected %0b", rsp_ch.hit, exp_res.hit));
        if (rsp_ch.evicted !== exp_res.evicted)
          report_mismatch($sformatf("evicted %0b, expected %0b",
                                    rsp_ch.evicted, exp_res.evicted));
        if (rsp_ch.hit_count !== exp_res.hits)
          report_mismatch($sformatf("hit_count %0d, expected %0d",
                                    rsp_ch.hit_count, exp_res.hits));
        if (rsp_ch.miss_count !== exp_res.misses)
          report_mismatch($sformatf("miss_count %0d, expected %0d",
                                    rsp_ch.miss_count, exp_res.misses));
      end
    end
  end

  // Watchdog: too many cycles without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.address = '0;
    rsp_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    quiet_cycles = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      rank_mem[i] = 0;
    end
    hit_total = '0;
    miss_total = '0;
    cur_offset = OFFSET_BITS_RST;
    cur_index = INDEX_BITS_RST;
    cur_ways = WAYS_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, no idling.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[i].sel, dir_rows[i].value);
      end else begin
        send_lookup(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: mostly a small working set so that hits and evictions
    // are common, the rest fully random addresses.
    foreach (phase_list[p]) begin
      wait_drained();
      write_reg(REG_OFFSET_BITS, 32'(phase_list[p].offset));
      write_reg(REG_INDEX_BITS, 32'(phase_list[p].index));
      write_reg(REG_WAYS_IN_USE, 32'(phase_list[p].ways));
      gap_pct = (phase_list[p].mode == IDLE_SEND) ? 49 :
                (phase_list[p].mode == IDLE_BOTH) ? 14 : 0;
      stall_pct = (phase_list[p].mode == IDLE_RECV) ? 49 :
                  (phase_list[p].mode == IDLE_BOTH) ? 14 : 0;
      foreach (tag_pool[t]) tag_pool[t] = $urandom;
      foreach (set_pool[s]) set_pool[s] = $urandom;
      for (int n = 0; n < PHASE_LEN; n++) begin
        // Long response hold-off while addresses keep coming.
        if (p == 0 && n == 10) hold_requests++;
        send_lookup(($urandom_range(99) < 80) ? pool_addr() : $urandom, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/salc_pkg.sv
rtl/salc_if.sv
rtl/salc_way_update.sv
rtl/set_assoc_lru_cache_lookup.sv
tb/tb_set_assoc_lru_cache_lookup.sv
